@@ src/ssh_pkg.sv @@
// Shared types, constants and lookup tables of the stream sync header scanner.
// No dependencies.
package ssh_pkg;

  localparam int CAPTURE_DEPTH = 6;
  localparam int CAP_IDX_W = $clog2(CAPTURE_DEPTH);
  localparam int DIV_STEPS = 26;

  localparam logic [1:0] MODE_SHORT = 2'd0;
  localparam logic [1:0] MODE_LONG  = 2'd1;
  localparam logic [1:0] MODE_AC3   = 2'd2;
  localparam logic [1:0] MODE_MPA   = 2'd3;

  localparam logic [7:0] PES_MIN_ID = 8'hBC;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } ssh_in_t;

  typedef struct packed {
    logic [31:0] header_position;
    logic [16:0] frame_size;
    logic [8:0]  header_size;
    logic [31:0] packet_length;
    logic        is_pes;
    logic        status;
  } ssh_out_t;

  typedef struct packed {
    logic take;
    logic eval;
    logic mul;
    logic scale;
    logic div_step;
    logic load_out;
  } ssh_cmd_t;

  typedef struct packed {
    logic hit;
    logic need_div;
    logic div_done;
  } ssh_stat_t;

  // AC-3 frame size in 16-bit words
  function automatic logic [10:0] ac3_words(input logic [1:0] fs, input logic [5:0] fc);
    logic [10:0] w;
    w = 11'd0;
    case (fs)
      2'd0: begin
        case (fc[5:1])
          5'd0: w = 11'd64;    5'd1: w = 11'd80;    5'd2: w = 11'd96;
          5'd3: w = 11'd112;   5'd4: w = 11'd128;   5'd5: w = 11'd160;
          5'd6: w = 11'd192;   5'd7: w = 11'd224;   5'd8: w = 11'd256;
          5'd9: w = 11'd320;   5'd10: w = 11'd384;  5'd11: w = 11'd448;
          5'd12: w = 11'd512;  5'd13: w = 11'd640;  5'd14: w = 11'd768;
          5'd15: w = 11'd896;  5'd16: w = 11'd1024; 5'd17: w = 11'd1152;
          5'd18: w = 11'd1280;
          default: w = 11'd0;
        endcase
      end
      2'd1: begin
        case (fc[5:1])
          5'd0: w = 11'd69;    5'd1: w = 11'd87;    5'd2: w = 11'd104;
          5'd3: w = 11'd121;   5'd4: w = 11'd139;   5'd5: w = 11'd174;
          5'd6: w = 11'd208;   5'd7: w = 11'd243;   5'd8: w = 11'd278;
          5'd9: w = 11'd348;   5'd10: w = 11'd417;  5'd11: w = 11'd487;
          5'd12: w = 11'd557;  5'd13: w = 11'd696;  5'd14: w = 11'd835;
          5'd15: w = 11'd975;  5'd16: w = 11'd1114; 5'd17: w = 11'd1253;
          5'd18: w = 11'd1393;
          default: w = 11'd0;
        endcase
        w = w + {10'd0, fc[0]};
      end
      2'd2: begin
        case (fc[5:1])
          5'd0: w = 11'd96;    5'd1: w = 11'd120;   5'd2: w = 11'd144;
          5'd3: w = 11'd168;   5'd4: w = 11'd192;   5'd5: w = 11'd240;
          5'd6: w = 11'd288;   5'd7: w = 11'd336;   5'd8: w = 11'd384;
          5'd9: w = 11'd480;   5'd10: w = 11'd576;  5'd11: w = 11'd672;
          5'd12: w = 11'd768;  5'd13: w = 11'd960;  5'd14: w = 11'd1152;
          5'd15: w = 11'd1344; 5'd16: w = 11'd1536; 5'd17: w = 11'd1728;
          5'd18: w = 11'd1920;
          default: w = 11'd0;
        endcase
      end
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  // MPEG audio bitrate in kbit/s; vi 0 = MPEG-1, 1 = MPEG-2, 2 = MPEG-2.5
  function automatic logic [8:0] mpa_kbps(input logic [1:0] vi, input logic [1:0] li,
                                          input logic [3:0] br);
    logic [8:0] k;
    k = 9'd0;
    if (vi == 2'd0) begin
      case (li)
        2'd0: begin
          k = (br == 4'd15) ? 9'd0 : {br, 5'd0};
        end
        2'd1: begin
          case (br)
            4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;   4'd4: k = 9'd64;
            4'd5: k = 9'd80;   4'd6: k = 9'd96;   4'd7: k = 9'd112;  4'd8: k = 9'd128;
            4'd9: k = 9'd160;  4'd10: k = 9'd192; 4'd11: k = 9'd224; 4'd12: k = 9'd256;
            4'd13: k = 9'd320; 4'd14: k = 9'd384;
            default: k = 9'd0;
          endcase
        end
        default: begin
          case (br)
            4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;   4'd4: k = 9'd56;
            4'd5: k = 9'd64;   4'd6: k = 9'd80;   4'd7: k = 9'd96;   4'd8: k = 9'd112;
            4'd9: k = 9'd128;  4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
            4'd13: k = 9'd256; 4'd14: k = 9'd320;
            default: k = 9'd0;
          endcase
        end
      endcase
    end else if (li == 2'd0) begin
      case (br)
        4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;   4'd4: k = 9'd64;
        4'd5: k = 9'd80;   4'd6: k = 9'd96;   4'd7: k = 9'd112;  4'd8: k = 9'd128;
        4'd9: k = 9'd144;  4'd10: k = 9'd160; 4'd11: k = 9'd176; 4'd12: k = 9'd192;
        4'd13: k = 9'd224; 4'd14: k = 9'd256;
        default: k = 9'd0;
      endcase
    end else begin
      case (br)
        4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;   4'd4: k = 9'd32;
        4'd5: k = 9'd40;   4'd6: k = 9'd48;   4'd7: k = 9'd56;   4'd8: k = 9'd64;
        4'd9: k = 9'd80;   4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
        4'd13: k = 9'd144; 4'd14: k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] mpa_rate(input logic [1:0] vi, input logic [1:0] sr);
    logic [15:0] r;
    r = 16'd1;
    case ({vi, sr})
      4'b0000: r = 16'd44100; 4'b0001: r = 16'd48000; 4'b0010: r = 16'd32000;
      4'b0100: r = 16'd22050; 4'b0101: r = 16'd24000; 4'b0110: r = 16'd16000;
      4'b1000: r = 16'd11025; 4'b1001: r = 16'd12000; 4'b1010: r = 16'd8000;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] mpa_slots(input logic [1:0] vi, input logic [1:0] li);
    logic [7:0] s;
    case (li)
      2'd0: s = 8'd12;
      2'd1: s = 8'd144;
      default: s = (vi == 2'd0) ? 8'd144 : 8'd72;
    endcase
    return s;
  endfunction

endpackage

@@ src/ssh_ctrl.sv @@
// Sequencer of the sync header scanner: input handshake, result evaluation steps,
// output register valid. Depends on ssh_pkg.
module ssh_ctrl import ssh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ssh_stat_t stat,
  output ssh_cmd_t  cmd
);

  typedef enum logic [2:0] {S_SCAN, S_EVAL, S_MUL, S_SCALE, S_DIV, S_OUT} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_SCAN);

  always_comb begin
    cmd = '0;
    cmd.take     = (state == S_SCAN) && in_valid;
    cmd.eval     = (state == S_EVAL);
    cmd.mul      = (state == S_MUL);
    cmd.scale    = (state == S_SCALE);
    cmd.div_step = (state == S_DIV);
    cmd.load_out = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SCAN;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_SCAN:  if (cmd.take && stat.hit) state <= S_EVAL;
        S_EVAL:  state <= stat.need_div ? S_MUL : S_OUT;
        S_MUL:   state <= S_SCALE;
        S_SCALE: state <= S_DIV;
        S_DIV:   if (stat.div_done) state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_SCAN;
        end
        default: state <= S_SCAN;
      endcase
    end
  end

endmodule

@@ src/ssh_datapath.sv @@
// Datapath of the sync header scanner: sync window, capture bytes, size decode,
// MPEG audio frame size divider and result register. Depends on ssh_pkg.
module ssh_datapath import ssh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wen,
  input  logic [1:0] cfg_wdata,
  input  ssh_in_t   in_data,
  input  ssh_cmd_t  cmd,
  output ssh_stat_t stat,
  output ssh_out_t  out_data
);

  logic [1:0]  mode;
  logic [31:0] sync_window;
  logic [31:0] byte_count;
  logic [7:0]  capture_bytes [CAPTURE_DEPTH];
  logic [2:0]  capture_phase;
  logic [31:0] pending_position;
  logic [31:0] last_position;
  logic        have_last;
  logic        imm_long;     // pending result is a bare 00 00 00 01

  // scan-side logic for the beat being taken
  logic [31:0] win0, win_next;
  logic [2:0]  cp0;
  logic [CAP_IDX_W-1:0] cidx;
  logic [7:0]  c0_eff;
  logic [2:0]  need;
  logic        finish_hit, long4_hit;

  always_comb begin
    win0     = in_data.restart ? 32'hFFFF_FFFF : sync_window;
    win_next = {win0[23:0], in_data.data_byte};
    cp0      = in_data.restart ? 3'd0 : capture_phase;
    cidx     = CAP_IDX_W'(cp0 - 3'd1);
    c0_eff   = (cp0 == 3'd1) ? in_data.data_byte : capture_bytes[0];
    case (mode)
      MODE_SHORT: need = (c0_eff < PES_MIN_ID) ? 3'd1 : 3'd3;
      MODE_LONG:  need = 3'd6;
      default:    need = 3'd3;
    endcase
    finish_hit = (cp0 != 3'd0) && !(cp0 < need);
    long4_hit  = (cp0 == 3'd0) && (mode == MODE_LONG) && (win_next == 32'd1);
  end

  assign stat.hit = finish_hit || long4_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_SHORT;
      sync_window      <= 32'hFFFF_FFFF;
      byte_count       <= 32'd0;
      capture_phase    <= 3'd0;
      pending_position <= 32'd0;
      imm_long         <= 1'b0;
    end else begin
      if (cfg_wen) mode <= cfg_wdata;
      if (cmd.take) begin
        byte_count  <= byte_count + 32'd1;
        sync_window <= win_next;
        imm_long    <= long4_hit;
        if (cp0 != 3'd0) begin
          if (32'(cidx) < CAPTURE_DEPTH) capture_bytes[cidx] <= in_data.data_byte;
          capture_phase <= finish_hit ? 3'd0 : cp0 + 3'd1;
        end else begin
          case (mode)
            MODE_SHORT: begin
              if (win_next[23:0] == 24'd1) begin
                pending_position <= byte_count - 32'd2;
                capture_phase    <= 3'd1;
              end else begin
                capture_phase <= 3'd0;
              end
            end
            MODE_LONG: begin
              if (win_next == 32'd1) begin
                pending_position <= byte_count - 32'd3;
                capture_phase    <= 3'd0;
              end else if (win_next[31:4] == 28'h000001E) begin
                pending_position <= byte_count - 32'd3;
                capture_bytes[0] <= in_data.data_byte;
                capture_phase    <= 3'd2;
              end else begin
                capture_phase <= 3'd0;
              end
            end
            MODE_AC3: begin
              if (win_next[15:0] == 16'h0B77) begin
                pending_position <= byte_count - 32'd1;
                capture_phase    <= 3'd1;
              end else begin
                capture_phase <= 3'd0;
              end
            end
            default: begin
              if (win_next[15:5] == 11'h7FF) begin
                pending_position <= byte_count - 32'd1;
                capture_bytes[0] <= in_data.data_byte;
                capture_phase    <= 3'd2;
              end else begin
                capture_phase <= 3'd0;
              end
            end
          endcase
        end
      end
    end
  end

  // header decode from captured bytes
  logic [7:0]  c0, c1, c2, c3, c5;
  logic [16:0] pes_len;
  logic        pes;
  logic [16:0] e_fs;
  logic [8:0]  e_hs;
  logic        e_pes, e_bad, e_div;
  logic [1:0]  id, layer, sr, vi, li;
  logic [3:0]  br;

  always_comb begin
    c0 = capture_bytes[0];
    c1 = capture_bytes[1];
    c2 = capture_bytes[2];
    c3 = capture_bytes[3];
    c5 = capture_bytes[5];
    pes_len = ({c1, c2} == 16'd0) ? 17'd0 : {1'b0, c1, c2} + 17'd6;
    pes     = (c0 >= PES_MIN_ID);
    id      = c0[4:3];
    layer   = c0[2:1];
    br      = c1[7:4];
    sr      = c1[3:2];
    vi      = (id == 2'd3) ? 2'd0 : (id == 2'd2) ? 2'd1 : 2'd2;
    li      = 2'd3 - layer;
    e_fs    = 17'd0;
    e_hs    = 9'd3;
    e_pes   = 1'b0;
    e_bad   = 1'b0;
    e_div   = 1'b0;
    if (imm_long) begin
      e_hs = 9'd4;
    end else begin
      case (mode)
        MODE_SHORT: begin
          e_pes = pes;
          e_fs  = pes ? pes_len : 17'd0;
        end
        MODE_LONG: begin
          e_pes = pes;
          e_fs  = pes ? pes_len : 17'd0;
          if (!pes) e_hs = 9'd4;
          else if (c3[7:6] == 2'b10) e_hs = 9'd9 + {1'b0, c5};
          else e_hs = 9'd6;
        end
        MODE_AC3: begin
          e_hs = 9'd2;
          if (c2[7:6] == 2'd3 || c2[5:0] >= 6'd38) e_bad = 1'b1;
          else e_fs = {5'd0, ac3_words(c2[7:6], c2[5:0]), 1'b0};
        end
        default: begin
          if (id == 2'd1 || layer == 2'd0 || br == 4'd15 || sr == 2'd3 || c2[1:0] == 2'd2)
            e_bad = 1'b1;
          else if (br != 4'd0)
            e_div = 1'b1;
        end
      endcase
    end
  end

  assign stat.need_div = e_div;

  // MPEG audio: slots * kbps * 1000 / rate, restoring divider one bit a cycle
  logic [7:0]  slots_r;
  logic [8:0]  kbps_r;
  logic [15:0] rate_r;
  logic        pad_r, slot4_r, use_div;
  logic [16:0] prod;
  logic [25:0] num;
  logic [16:0] rem;
  logic [4:0]  div_cnt;
  logic [16:0] trial;
  logic [16:0] r_fs;
  logic [8:0]  r_hs;
  logic        r_pes, r_bad;

  assign trial         = {rem[15:0], num[25]};
  assign stat.div_done = (div_cnt == 5'd1);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      r_fs    <= e_fs;
      r_hs    <= e_hs;
      r_pes   <= e_pes;
      r_bad   <= e_bad;
      use_div <= e_div;
      slots_r <= mpa_slots(vi, li);
      kbps_r  <= mpa_kbps(vi, li, br);
      rate_r  <= mpa_rate(vi, sr);
      pad_r   <= c1[1];
      slot4_r <= (li == 2'd0);
    end
    if (cmd.mul) prod <= 17'(slots_r * kbps_r);
    if (cmd.scale) begin
      num     <= 26'(prod * 10'd1000);
      rem     <= 17'd0;
      div_cnt <= 5'(DIV_STEPS);
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt - 5'd1;
      if (trial >= {1'b0, rate_r}) begin
        rem <= trial - {1'b0, rate_r};
        num <= {num[24:0], 1'b1};
      end else begin
        rem <= trial;
        num <= {num[24:0], 1'b0};
      end
    end
  end

  // result register and previous header tracking
  logic [16:0] q_pad;
  logic [16:0] fin_fs;

  assign q_pad  = num[16:0] + {16'd0, pad_r};
  assign fin_fs = use_div ? (slot4_r ? {q_pad[14:0], 2'b00} : q_pad) : r_fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= 32'd0;
      have_last     <= 1'b0;
    end else begin
      if (cmd.take && in_data.restart) begin
        last_position <= 32'd0;
        have_last     <= 1'b0;
      end
      if (cmd.load_out && !r_bad) begin
        last_position <= pending_position;
        have_last     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.header_position <= pending_position;
      out_data.frame_size      <= fin_fs;
      out_data.header_size     <= r_hs;
      out_data.packet_length   <= have_last ? pending_position - last_position : 32'd0;
      out_data.is_pes          <= r_pes;
      out_data.status          <= r_bad;
    end
  end

endmodule

@@ src/stream_sync_header_scanner.sv @@
// Stream sync header scanner: one byte per beat; a header ends with one result beat.
// Bytes are taken one per cycle while scanning and capturing. After the byte that
// completes a header the input stalls while the result is evaluated and loaded,
// longer for an MPEG audio header with a bitrate (serial divider) and while a held
// result beat waits on out_stall; the result beat is valid when the stall ends.
// Synchronous active-high reset: mode 0, window all ones, counters and valid cleared.
module stream_sync_header_scanner import ssh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  ssh_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ssh_out_t   out_data
);

  ssh_cmd_t  cmd;
  ssh_stat_t stat;

  ssh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssh_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

@@ test/stream_sync_header_scanner_tb.sv @@
// Self-checking testbench for the stream sync header scanner.
// Depends on ssh_pkg and stream_sync_header_scanner; predicts header results per byte beat.
`timescale 1ns / 1ps

module stream_sync_header_scanner_tb;
  import ssh_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_wdata = MODE_SHORT;
  logic in_valid = 1'b0;
  logic in_stall;
  ssh_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ssh_out_t out_data;

  stream_sync_header_scanner u_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // scanner shadow state
  logic [1:0]  cur_mode;
  logic [31:0] win;
  logic [31:0] byte_pos;
  logic [7:0]  cap [CAPTURE_DEPTH];
  int unsigned phase;
  logic [31:0] hdr_pos;
  logic [31:0] prev_pos;
  bit          prev_ok;

  ssh_in_t  byte_queue[$];
  ssh_out_t header_queue[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_ctr = 0;
  int stall_style = 0;

  function automatic int unsigned ac3_size_words(int unsigned fs, int unsigned fc);
    int unsigned base [19];
    int unsigned w;
    base = '{64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640, 768,
             896, 1024, 1152, 1280};
    w = base[fc / 2];
    if (fs == 1) w = (w * 480) / 441 + (fc % 2);
    else if (fs == 2) w = w * 3 / 2;
    return w;
  endfunction

  function automatic int unsigned kbps_of(int unsigned vi, int unsigned li, int unsigned br);
    int unsigned t1l1 [16], t1l2 [16], t1l3 [16], t2l1 [16], t2lx [16];
    t1l1 = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
    t1l2 = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
    t1l3 = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
    t2l1 = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
    t2lx = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
    if (vi == 0) return (li == 0) ? t1l1[br] : (li == 1) ? t1l2[br] : t1l3[br];
    return (li == 0) ? t2l1[br] : t2lx[br];
  endfunction

  function automatic ssh_out_t make_header(logic [31:0] pos, int unsigned fsize,
                                           int unsigned hsize, bit pes, bit bad);
    ssh_out_t r;
    r.header_position = pos;
    r.frame_size = fsize[16:0];
    r.header_size = hsize[8:0];
    r.packet_length = prev_ok ? pos - prev_pos : 32'd0;
    r.is_pes = pes;
    r.status = bad;
    if (!bad) begin
      prev_pos = pos;
      prev_ok = 1;
    end
    return r;
  endfunction

  function automatic int unsigned pes_len();
    int unsigned len;
    len = {cap[1], cap[2]};
    return (len != 0) ? len + 6 : 0;
  endfunction

  function automatic ssh_out_t complete_header();
    int unsigned id, layer, br, sr, pad, emph, vi, li, n, rate, slots;
    int unsigned rates [9];
    rates = '{44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000};
    case (cur_mode)
      MODE_SHORT: begin
        if (cap[0] >= PES_MIN_ID) return make_header(hdr_pos, pes_len(), 3, 1, 0);
        return make_header(hdr_pos, 0, 3, 0, 0);
      end
      MODE_LONG: begin
        if (cap[0] < PES_MIN_ID) return make_header(hdr_pos, 0, 4, 0, 0);
        return make_header(hdr_pos, pes_len(), (cap[3][7:6] == 2'b10) ? 9 + cap[5] : 6,
                           1, 0);
      end
      MODE_AC3: begin
        if (cap[2][7:6] == 2'd3 || cap[2][5:0] >= 38) return make_header(hdr_pos, 0, 2, 0, 1);
        return make_header(hdr_pos, 2 * ac3_size_words(cap[2][7:6], cap[2][5:0]), 2, 0, 0);
      end
      default: begin
        id = cap[0][4:3]; layer = cap[0][2:1];
        br = cap[1][7:4]; sr = cap[1][3:2]; pad = cap[1][1]; emph = cap[2][1:0];
        if (id == 1 || layer == 0 || br == 15 || sr == 3 || emph == 2)
          return make_header(hdr_pos, 0, 3, 0, 1);
        vi = (id == 3) ? 0 : (id == 2) ? 1 : 2;
        li = 3 - layer;
        if (br == 0) return make_header(hdr_pos, 0, 3, 0, 0);
        rate = rates[vi * 3 + sr];
        slots = (li == 0) ? 12 : (li == 1 || vi == 0) ? 144 : 72;
        n = slots * (1000 * kbps_of(vi, li, br)) / rate;
        return make_header(hdr_pos, (n + pad) * ((li == 0) ? 4 : 1), 3, 0, 0);
      end
    endcase
  endfunction

  task automatic scan_byte(ssh_in_t it);
    logic [31:0] p;
    int unsigned need;
    p = byte_pos;
    byte_pos = byte_pos + 1;
    if (it.restart) begin
      win = '1; phase = 0; prev_pos = 0; prev_ok = 0;
    end
    win = {win[23:0], it.data_byte};
    if (phase != 0) begin
      if (phase - 1 < CAPTURE_DEPTH) cap[phase - 1] = it.data_byte;
      case (cur_mode)
        MODE_SHORT: need = (phase >= 1 && cap[0] < PES_MIN_ID) ? 1 : 3;
        MODE_LONG: need = 6;
        default: need = 3;
      endcase
      if (phase < need) begin
        phase++;
        return;
      end
      phase = 0;
      header_queue.push_back(complete_header());
      return;
    end
    case (cur_mode)
      MODE_SHORT:
        if (win[23:0] == 24'h000001) begin
          hdr_pos = p - 2; phase = 1;
        end
      MODE_LONG: begin
        if (win == 32'h00000001) header_queue.push_back(make_header(p - 3, 0, 4, 0, 0));
        else if (win[31:4] == 28'h000001E) begin
          hdr_pos = p - 3; cap[0] = it.data_byte; phase = 2;
        end
      end
      MODE_AC3:
        if (win[15:0] == 16'h0B77) begin
          hdr_pos = p - 1; phase = 1;
        end
      default:
        if (win[15:5] == 11'h7FF) begin
          hdr_pos = p - 1; cap[0] = it.data_byte; phase = 2;
        end
    endcase
  endtask

  // driver: bursts and gaps; payload holds while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold
    end else begin
      if (in_valid) scan_byte(in_data);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_ctr == 0) begin
      stall_ctr = $urandom_range(5, 60);
      stall_style = $urandom_range(0, 3);
    end else stall_ctr--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= stall_ctr[0];
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (header_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", out_data);
      end else begin
        ssh_out_t e;
        e = header_queue.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  task automatic push_byte(int unsigned b, bit rs = 0);
    ssh_in_t it;
    it.data_byte = b[7:0];
    it.restart = rs;
    byte_queue.push_back(it);
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || header_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_mode = m;
  endtask

  // header sequence with random content, mode dependent; AC-3 and MPEG audio fields are sometimes malformed
  task automatic push_header(logic [1:0] m);
    int unsigned k;
    case (m)
      MODE_SHORT: begin
        push_byte(0); push_byte(0); push_byte(1);
        push_byte($urandom_range(0, 1) ? $urandom_range(8'hBC, 255) : $urandom_range(0, 255));
        repeat (2) push_byte($urandom_range(0, 255));
      end
      MODE_LONG: begin
        push_byte(0); push_byte(0);
        if ($urandom_range(0, 3) == 0) begin
          push_byte(0); push_byte(1);
        end else begin
          push_byte(1); push_byte(8'hE0 | $urandom_range(0, 15));
          push_byte($urandom_range(0, 255)); push_byte($urandom_range(0, 255));
          push_byte($urandom_range(0, 1) ? 8'h80 | $urandom_range(0, 63)
                                          : $urandom_range(0, 255));
          repeat (2) push_byte($urandom_range(0, 255));
        end
      end
      MODE_AC3: begin
        push_byte(8'h0B); push_byte(8'h77);
        repeat (2) push_byte($urandom_range(0, 255));
        k = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                      : ($urandom_range(0, 2) << 6) | $urandom_range(0, 37);
        push_byte(k);
      end
      default: begin
        push_byte(8'hFF);
        k = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31)
                                      : ($urandom_range(0, 1) ? 8'h18 : 8'h10) |
                                        ($urandom_range(1, 3) << 1) | $urandom_range(0, 1);
        push_byte(8'hE0 | k);
        k = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                      : ($urandom_range(0, 14) << 4) |
                                        ($urandom_range(0, 2) << 2) | $urandom_range(0, 3);
        push_byte(k);
        push_byte($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                            : ($urandom_range(0, 63) << 2) | 2'd1);
      end
    endcase
  endtask

  initial begin
    int n;
    logic [1:0] m;
    cur_mode = MODE_SHORT; win = '1; byte_pos = 0; phase = 0;
    hdr_pos = 0; prev_pos = 0; prev_ok = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: each mode with edge headers
    set_mode(MODE_SHORT);
    push_byte(0); push_byte(0); push_byte(1); push_byte(8'hFF);
    push_byte(8'hFF); push_byte(8'hFF);
    push_byte(0); push_byte(0); push_byte(1); push_byte(8'h00);
    drain();
    set_mode(MODE_LONG);
    push_byte(0); push_byte(0); push_byte(0); push_byte(1);
    push_byte(0); push_byte(0); push_byte(1); push_byte(8'hEF);
    push_byte(0); push_byte(0); push_byte(8'h80); push_byte(0); push_byte(8'hFF);
    drain();
    set_mode(MODE_AC3);
    push_byte(8'h0B); push_byte(8'h77); push_byte(0); push_byte(0); push_byte(8'hC0);
    push_byte(8'h0B); push_byte(8'h77); push_byte(0); push_byte(0); push_byte(8'h65);
    drain();
    set_mode(MODE_MPA);
    push_byte(8'hE2, 1); push_byte(8'hE0); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'hE3); push_byte(8'h04); push_byte(8'h00);
    drain();

    // random phases; occasional header-less noise bytes and rare restarts
    for (int ph = 0; ph < 8; ph++) begin
      m = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
      set_mode(m);
      n = 0;
      while (n < 48) begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte($urandom_range(0, 255), $urandom_range(0, 15) == 0);
          n++;
        end else begin
          push_header(m);
          n += 5;
        end
      end
      drain();
    end
    if (mismatches == 0 && header_queue.size() == 0)
      $display("stream_sync_header_scanner regression: pass");
    else
      $display("stream_sync_header_scanner regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("stream_sync_header_scanner regression: fail");
    $finish;
  end

endmodule
